/* hdl/pods_pkg.sv */
// ----------------------------------------------------------------------------
// pods_pkg: shared types and constants for the overlay dwell selector
// Overlay codes, stage codes and the request and result payload types.
// ----------------------------------------------------------------------------
package pods_pkg;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned DWELL_W = 16;
  localparam int unsigned CD_W    = 16;
  localparam int unsigned GAP_W   = DWELL_W + 4;

  localparam logic [7:0] STAGE_IN_MATCH   = 8'd4;
  localparam logic [7:0] STAGE_SETTLEMENT = 8'd5;

  localparam logic [1:0] FRESH_NEVER = 2'd0;
  localparam logic [1:0] FRESH_STALE = 2'd1;

  typedef enum logic [2:0] {
    OV_NONE       = 3'd0,
    OV_PREMATCH   = 3'd1,
    OV_PAUSED     = 3'd2,
    OV_ELIMINATED = 3'd3,
    OV_SETTLEMENT = 3'd4,
    OV_WAITING    = 3'd5,
    OV_LINKLOST   = 3'd6
  } overlay_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [1:0]        freshness;
    logic              stage_known;
    logic [7:0]        stage_code;
    logic              health_known;
    logic [15:0]       own_health;
    logic              pause_flag;
    logic [CD_W-1:0]   countdown_in;
  } in_item_t;

  typedef struct packed {
    overlay_t        overlay;
    logic [CD_W-1:0] countdown_out;
  } out_item_t;

  // Decision request handed from the input stage to the dwell core.
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] now_ms;
    overlay_t          target;
    logic [CD_W-1:0]   countdown;
  } step_t;

endpackage

/* hdl/pods_if.sv */
// ----------------------------------------------------------------------------
// pods_in_if / pods_out_if: valid-ready channels of the selector
// One interface for requests and one for results, each with two modports.
// ----------------------------------------------------------------------------
interface pods_in_if;
  import pods_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pods_out_if;
  import pods_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/pods_target.sv */
// ----------------------------------------------------------------------------
// pods_target: fixed-priority target overlay picker
// Maps one status snapshot to the overlay it asks for.
// ----------------------------------------------------------------------------
module pods_target (
  input  pods_pkg::in_item_t item,
  output pods_pkg::overlay_t target
);
  import pods_pkg::*;

  // Freshness code 3 falls through like fresh.
  always_comb begin
    if (item.freshness == FRESH_NEVER) begin
      target = OV_WAITING;
    end else if (item.freshness == FRESH_STALE) begin
      target = OV_LINKLOST;
    end else if (item.stage_known && item.stage_code == STAGE_SETTLEMENT) begin
      target = OV_SETTLEMENT;
    end else if (item.health_known && item.own_health == 16'd0) begin
      target = OV_ELIMINATED;
    end else if (item.pause_flag) begin
      target = OV_PAUSED;
    end else if (item.stage_known && item.stage_code < STAGE_IN_MATCH) begin
      target = OV_PREMATCH;
    end else begin
      target = OV_NONE;
    end
  end

endmodule

/* hdl/pods_core.sv */
// ----------------------------------------------------------------------------
// pods_core: dwell state, decision logic and result register
// Updates the shown overlay once per request and registers the result.
// ----------------------------------------------------------------------------
module pods_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pods_pkg::DWELL_W-1:0]  cfg_wdata,
  input  pods_pkg::step_t               step,
  output logic                          step_ready,
  pods_out_if.source                    out_ch
);
  import pods_pkg::*;

  logic [DWELL_W-1:0] dwell_r;
  overlay_t           shown_r, shown_nxt;
  logic               since_valid_r, since_valid_nxt;
  logic [TIME_W-1:0]  since_r, since_nxt;
  logic               last_valid_r;
  logic [TIME_W-1:0]  last_r;
  logic               out_valid_r;
  out_item_t          out_r, out_nxt;

  logic [TIME_W:0]    last_diff;
  logic [TIME_W:0]    since_diff;
  logic [TIME_W-1:0]  since_eff;
  logic [GAP_W-1:0]   gap_limit;
  logic               trusted;
  logic               gap;
  logic               done;
  logic               fire;

  assign step_ready = !out_valid_r || out_ch.ready;
  assign fire       = step.valid && step_ready;

  // Ten dwells as shift-and-add.
  assign gap_limit = {1'b0, dwell_r, 3'b000} + {3'b000, dwell_r, 1'b0};

  // The top bit of each difference is the borrow, set when time is below.
  assign last_diff = {1'b0, step.now_ms} - {1'b0, last_r};
  assign trusted   = !last_valid_r || !last_diff[TIME_W];
  assign gap       = last_valid_r && !last_diff[TIME_W] && (dwell_r != '0) &&
                     (last_diff[TIME_W-1:0] >= {{(TIME_W-GAP_W){1'b0}}, gap_limit});

  assign since_eff  = (gap && since_valid_r) ? step.now_ms : since_r;
  assign since_diff = {1'b0, step.now_ms} - {1'b0, since_eff};
  assign done       = !since_valid_r ||
                      (trusted && !since_diff[TIME_W] &&
                       since_diff[TIME_W-1:0] >=
                         {{(TIME_W-DWELL_W){1'b0}}, dwell_r});

  always_comb begin
    shown_nxt       = shown_r;
    since_valid_nxt = since_valid_r;
    since_nxt       = since_eff;
    out_nxt         = out_r;
    out_nxt.overlay = shown_r;
    if (step.target == shown_r) begin
      out_nxt.countdown_out = step.countdown;
    end else if (step.target > shown_r) begin
      shown_nxt             = step.target;
      since_valid_nxt       = 1'b1;
      since_nxt             = step.now_ms;
      out_nxt.countdown_out = step.countdown;
    end else if (done) begin
      shown_nxt             = step.target;
      out_nxt.countdown_out = step.countdown;
      if (step.target == OV_NONE) begin
        since_valid_nxt = 1'b0;
        since_nxt       = '0;
      end else begin
        since_valid_nxt = 1'b1;
        since_nxt       = step.now_ms;
      end
    end
    out_nxt.overlay = shown_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r       <= '0;
      shown_r       <= OV_NONE;
      since_valid_r <= 1'b0;
      since_r       <= '0;
      last_valid_r  <= 1'b0;
      last_r        <= '0;
      out_valid_r   <= 1'b0;
      out_r         <= '0;
    end else begin
      if (cfg_we) begin
        dwell_r <= cfg_wdata;
      end
      if (fire) begin
        shown_r       <= shown_nxt;
        since_valid_r <= since_valid_nxt;
        since_r       <= since_nxt;
        last_valid_r  <= 1'b1;
        last_r        <= step.now_ms;
        out_r         <= out_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // The result register always mirrors the shown overlay.
  a_out_mirrors_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.overlay == shown_r)
    else $error("result overlay differs from shown overlay");

  // No overlay shown means no dwell timestamp is being tracked.
  a_none_no_since: assert property (@(posedge clk) disable iff (!rst_n)
    shown_r == OV_NONE |-> !since_valid_r)
    else $error("dwell timestamp valid while no overlay is shown");

  // An escalation always starts the dwell timer at the request time.
  a_escalation_stamps: assert property (@(posedge clk) disable iff (!rst_n)
    fire && step.target > shown_r |=> since_valid_r && since_r == $past(step.now_ms))
    else $error("escalation did not restart the dwell timer");

  // The shown overlay changes only when a request is taken.
  a_change_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(shown_r))
    else $error("shown overlay changed without a request");

endmodule

/* hdl/priority_overlay_dwell_selector_top.sv */
// ----------------------------------------------------------------------------
// priority_overlay_dwell_selector_top: overlay selector with minimum dwell
// Input register, target picker and dwell core with its result register.
// ----------------------------------------------------------------------------
// Usage: status snapshots arrive on in_ch as valid-ready requests, one per
// rising edge at which valid and ready are both high. Each request yields
// exactly one result on out_ch: the overlay now shown and its countdown.
// The user must write the minimum dwell through cfg_we / cfg_wdata only
// while the block is idle; the block does not enforce this. It takes effect
// on the next request. A request passes through the input register, then the
// target pick and dwell decision run in a single pass into the result
// register. Throughput is one request per cycle while out_ch does not stall,
// since the dwell state is updated in a single step and each decision needs
// the state left by the one before.
// While out_ch stalls, the finished result waits in the result register and
// one more request is still taken into the input register; after that,
// in_ch.ready drops until the receiver takes the result.
// A synchronous active-low reset on rst_n clears the dwell to zero, shows no
// overlay, forgets all timestamps and empties both registers.
// ----------------------------------------------------------------------------
module priority_overlay_dwell_selector_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pods_pkg::DWELL_W-1:0]  cfg_wdata,
  pods_in_if.sink                       in_ch,
  pods_out_if.source                    out_ch
);
  import pods_pkg::*;

  // Input register: holds one request until the core takes it.
  logic     s1_valid_r;
  in_item_t s1_item_r;
  overlay_t s1_target;
  logic     core_ready;
  step_t    step;

  assign in_ch.ready = !s1_valid_r || core_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // The payload needs no reset; it is loaded with every accepted request.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= in_ch.data;
    end
  end

  pods_target u_target (
    .item   (s1_item_r),
    .target (s1_target)
  );

  // Bundle the decision request for the core.
  always_comb begin
    step.valid     = s1_valid_r;
    step.now_ms    = s1_item_r.now_ms;
    step.target    = s1_target;
    step.countdown = s1_item_r.countdown_in;
  end

  pods_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .step       (step),
    .step_ready (core_ready),
    .out_ch     (out_ch)
  );

endmodule

/* dv/tb_priority_overlay_dwell_selector_top.sv */
// ----------------------------------------------------------------------------
// tb_priority_overlay_dwell_selector_top: self-checking bench for the selector
// A scoreboard model of the overlay priority and dwell rules predicts every
// result. Directed requests cover each overlay, the dwell hold and release,
// backwards time, the forward clock gap and the field extremes. Random
// sequences then run under several dwell settings and handshake patterns.
// ----------------------------------------------------------------------------
module tb_priority_overlay_dwell_selector_top;
  import pods_pkg::*;

  // Far above the length of the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_MAX  = 10;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [DWELL_W-1:0] cfg_wdata;

  pods_in_if  in_ch ();
  pods_out_if out_ch ();

  priority_overlay_dwell_selector_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // --------------------------------------------------------------------------
  // Scoreboard copy of the selector state. It starts in the reset state and
  // moves one step for every request the block accepts.
  // --------------------------------------------------------------------------
  logic [DWELL_W-1:0] sel_dwell       = '0;
  overlay_t           sel_shown       = OV_NONE;
  logic               sel_since_valid = 1'b0;
  logic [TIME_W-1:0]  sel_since_time  = '0;
  logic               sel_last_valid  = 1'b0;
  logic [TIME_W-1:0]  sel_last_time   = '0;
  logic [CD_W-1:0]    sel_held_cd     = '0;

  out_item_t overlay_expect_q[$];

  int unsigned cycle_count     = 0;
  int unsigned error_count     = 0;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned dwell_writes    = 0;

  // Handshake shaping. The percentages are the chance per cycle that a side
  // sits idle; hold_off_left forces the receiver to stall until it counts down to zero.
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_off_left = 0;
  bit          offering      = 1'b0;

  // State of the random sequence generator.
  logic [TIME_W-1:0] rand_clock = '0;
  overlay_t          rand_want  = OV_NONE;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Target pick: the first matching condition in priority order wins.
  // Freshness code 3 falls through to the fresh branches on its own.
  // --------------------------------------------------------------------------
  function automatic overlay_t target_of(in_item_t s);
    if (s.freshness == FRESH_NEVER) return OV_WAITING;
    if (s.freshness == FRESH_STALE) return OV_LINKLOST;
    if (s.stage_known && s.stage_code == STAGE_SETTLEMENT) return OV_SETTLEMENT;
    if (s.health_known && s.own_health == 16'd0) return OV_ELIMINATED;
    if (s.pause_flag) return OV_PAUSED;
    if (s.stage_known && s.stage_code < STAGE_IN_MATCH) return OV_PREMATCH;
    return OV_NONE;
  endfunction

  // One decision step of the selector; returns the result it must produce.
  function automatic out_item_t advance_selector(in_item_t s);
    logic [TIME_W-1:0] now;
    overlay_t          tgt;
    logic              trusted;
    logic              done;
    out_item_t         res;
    now     = s.now_ms;
    trusted = 1'b1;
    // A step before the previous time cannot complete a dwell. A long forward
    // jump restarts the dwell timer of the overlay being shown.
    if (sel_last_valid) begin
      if (now < sel_last_time) begin
        trusted = 1'b0;
      end else if (sel_dwell != '0 &&
                   (now - sel_last_time) >= TIME_W'(sel_dwell) * TIME_W'(10)) begin
        if (sel_since_valid) sel_since_time = now;
      end
    end
    sel_last_valid = 1'b1;
    sel_last_time  = now;

    tgt = target_of(s);
    if (tgt == sel_shown) begin
      sel_held_cd = s.countdown_in;
    end else if (tgt > sel_shown) begin
      sel_shown       = tgt;
      sel_since_valid = 1'b1;
      sel_since_time  = now;
      sel_held_cd     = s.countdown_in;
    end else begin
      done = !sel_since_valid ||
             (trusted && now >= sel_since_time &&
              (now - sel_since_time) >= TIME_W'(sel_dwell));
      if (done) begin
        sel_shown       = tgt;
        sel_since_valid = (tgt != OV_NONE);
        sel_since_time  = (tgt != OV_NONE) ? now : '0;
        sel_held_cd     = s.countdown_in;
      end
    end
    res.overlay       = sel_shown;
    res.countdown_out = sel_held_cd;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Valid is only raised when it is low and only lowered when
  // it is high, so each time step carries at most one assignment to it.
  // --------------------------------------------------------------------------
  task automatic stop_offering();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_status(in_item_t s);
    in_ch.data <= s;
    if (!offering) begin
      in_ch.valid <= 1'b1;
      offering = 1'b1;
    end
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    overlay_expect_q.push_back(advance_selector(s));
    requests_sent++;
    // Random idle cycles after the accepted request.
    if ($urandom_range(99) < src_idle_pct) begin
      stop_offering();
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
  endtask

  // Sender pause: nothing is offered until every result is in.
  task automatic wait_all_results();
    stop_offering();
    while (overlay_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The dwell register is only written while the block is idle.
  task automatic set_dwell(logic [DWELL_W-1:0] value);
    wait_all_results();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sel_dwell = value;
    dwell_writes++;
  endtask

  function automatic in_item_t status(logic [TIME_W-1:0] now, logic [1:0] fr,
                                      logic sk, logic [7:0] stage, logic hk,
                                      logic [15:0] hp, logic pause,
                                      logic [CD_W-1:0] cd);
    in_item_t s;
    s.now_ms       = now;
    s.freshness    = fr;
    s.stage_known  = sk;
    s.stage_code   = stage;
    s.health_known = hk;
    s.own_health   = hp;
    s.pause_flag   = pause;
    s.countdown_in = cd;
    return s;
  endfunction

  // Builds a random snapshot whose target is the requested overlay. Fields of
  // lower priority than the target stay fully random.
  function automatic in_item_t make_status(overlay_t want, logic [TIME_W-1:0] now);
    in_item_t s;
    s = status(now, {1'b1, 1'($urandom_range(1))}, 1'($urandom_range(1)),
               8'($urandom_range(255)), 1'($urandom_range(1)),
               16'($urandom_range(65535)), 1'($urandom_range(1)),
               16'($urandom_range(65535)));
    if (want == OV_WAITING) begin
      s.freshness = FRESH_NEVER;
    end else if (want == OV_LINKLOST) begin
      s.freshness = FRESH_STALE;
    end else if (want == OV_SETTLEMENT) begin
      s.stage_known = 1'b1;
      s.stage_code  = STAGE_SETTLEMENT;
    end else begin
      if (s.stage_code == STAGE_SETTLEMENT) s.stage_known = 1'b0;
      if (want == OV_ELIMINATED) begin
        s.health_known = 1'b1;
        s.own_health   = 16'd0;
      end else begin
        if (s.health_known && s.own_health == 16'd0) s.own_health = 16'd1;
        // An unknown health of zero must not count as eliminated.
        if (!s.health_known && $urandom_range(3) == 0) s.own_health = 16'd0;
        if (want == OV_PAUSED) begin
          s.pause_flag = 1'b1;
        end else begin
          s.pause_flag = 1'b0;
          if (want == OV_PREMATCH) begin
            s.stage_known = 1'b1;
            s.stage_code  = 8'($urandom_range(3));
          end else if (s.stage_known && s.stage_code < STAGE_IN_MATCH) begin
            s.stage_code = s.stage_code | 8'h08;
          end
        end
      end
    end
    return s;
  endfunction

  // Time mostly creeps forward around the dwell, with some backwards steps,
  // some long gaps and the odd jump anywhere in the 48-bit range.
  function automatic logic [TIME_W-1:0] next_time(logic [TIME_W-1:0] t);
    int unsigned r;
    int unsigned span;
    span = 2 * int'(sel_dwell) + 3;
    r    = $urandom_range(99);
    if (r < 2) return {16'($urandom_range(65535)), 32'($urandom())};
    if (r < 8) return t - TIME_W'($urandom_range(span, 1));
    if (r < 14) return t + TIME_W'(sel_dwell) * TIME_W'(10) + TIME_W'($urandom_range(span));
    return t + TIME_W'($urandom_range(span));
  endfunction

  task automatic send_random_status();
    rand_clock = next_time(rand_clock);
    // Targets tend to repeat, so dwells get to run out as well as be cut.
    if ($urandom_range(99) >= 45) rand_want = overlay_t'(3'($urandom_range(6)));
    send_status(make_status(rand_want, rand_clock));
  endtask

  // --------------------------------------------------------------------------
  // Result side: random ready, with a forced stall counted down here.
  // --------------------------------------------------------------------------
  initial begin : ready_driver
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (overlay_expect_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("ERROR: result with nothing expected: overlay %0d countdown %0d",
                   out_ch.data.overlay, out_ch.data.countdown_out);
      end else begin
        want = overlay_expect_q.pop_front();
        results_checked++;
        if (out_ch.data.overlay !== want.overlay ||
            out_ch.data.countdown_out !== want.countdown_out) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("ERROR: result %0d: overlay exp %0d got %0d, countdown exp %0d got %0d",
                     results_checked, want.overlay, out_ch.data.overlay,
                     want.countdown_out, out_ch.data.countdown_out);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: run stopped after %0d cycles, %0d results still expected",
             cycle_count, overlay_expect_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // With the reset dwell of zero, each higher overlay must appear at once;
  // the very first request can never count as backwards. Freshness code 3 is
  // taken as fresh, and a repeated target only refreshes the countdown.
  task automatic test_escalation_order();
    send_status(status(48'd0,  2'd2, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0, 16'd100));
    send_status(status(48'd10, 2'd2, 1'b1, 8'd0, 1'b0, 16'd1, 1'b0, 16'd101));
    send_status(status(48'd20, 2'd3, 1'b1, 8'd0, 1'b0, 16'd1, 1'b1, 16'd102));
    send_status(status(48'd30, 2'd2, 1'b1, 8'd4, 1'b1, 16'd0, 1'b1, 16'd103));
    send_status(status(48'd40, 2'd2, 1'b1, 8'd5, 1'b1, 16'd0, 1'b1, 16'd104));
    send_status(status(48'd50, 2'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0, 16'd105));
    send_status(status(48'd60, 2'd1, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0, 16'd106));
    send_status(status(48'd60, 2'd1, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0, 16'd107));
  endtask

  // Dwell of 100: a lower target must wait the dwell out, and a backwards step
  // or a step still short of the dwell keeps the shown overlay.
  task automatic test_dwell_hold_and_release();
    set_dwell(16'd100);
    // The jump from 60 to 2000 is a forward gap and restarts the timer.
    send_status(status(48'd2000, 2'd1, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0, 16'd200));
    send_status(status(48'd2050, 2'd2, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0, 16'd201));
    send_status(status(48'd2100, 2'd2, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0, 16'd202));
    send_status(status(48'd2101, 2'd2, 1'b1, 8'd2, 1'b0, 16'd0, 1'b0, 16'd203));
    send_status(status(48'd2050, 2'd2, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0, 16'd204));
    send_status(status(48'd2150, 2'd2, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0, 16'd205));
    send_status(status(48'd2300, 2'd2, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0, 16'd206));
  endtask

  // Time before the shown-since stamp refuses the dwell even when the step is
  // not backwards, and a gap of ten dwells restarts the timer at the new time.
  task automatic test_backwards_and_gap();
    send_status(status(48'd3000, 2'd2, 1'b0, 8'd0, 1'b0, 16'd9, 1'b1, 16'd300));
    send_status(status(48'd2500, 2'd2, 1'b0, 8'd0, 1'b0, 16'd9, 1'b0, 16'd301));
    send_status(status(48'd2600, 2'd2, 1'b0, 8'd0, 1'b0, 16'd9, 1'b0, 16'd302));
    send_status(status(48'd4200, 2'd2, 1'b0, 8'd0, 1'b0, 16'd9, 1'b0, 16'd303));
    send_status(status(48'd4300, 2'd2, 1'b0, 8'd0, 1'b0, 16'd9, 1'b0, 16'd304));
  endtask

  // All-ones and all-zeros fields, the wrap from the top of time to zero and
  // the largest dwell running out exactly.
  task automatic test_field_extremes();
    send_status(status({TIME_W{1'b1}}, 2'd3, 1'b1, 8'hFF, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF));
    send_status(status(48'd0, 2'd0, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 16'h0000));
    send_status(status(48'd0, 2'd0, 1'b1, 8'hFF, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF));
    set_dwell(16'hFFFF);
    send_status(status(48'd0, 2'd2, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 16'd1));
    send_status(status(48'd65535, 2'd2, 1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, 16'd2));
  endtask

  // Random sequences under one handshake pattern; the dwell is rewritten every
  // sixty requests, starting from first_dwell.
  task automatic test_random_traffic(int unsigned count, int unsigned src_pct,
                                     int unsigned sink_pct, logic [DWELL_W-1:0] first_dwell);
    int unsigned dwell_pick[7] = '{0, 1, 3, 25, 250, 4000, 65535};
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == 0) begin
        set_dwell(first_dwell);
      end else if (i % 60 == 0) begin
        if ($urandom_range(7) == 0) set_dwell(16'($urandom_range(65535)));
        else set_dwell(16'(dwell_pick[$urandom_range(6)]));
      end
      send_random_status();
    end
    wait_all_results();
  endtask

  // The receiver stalls for a long stretch while requests keep coming, so the
  // block fills up and holds its input off.
  task automatic test_receiver_hold_off();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_dwell(16'd20);
    hold_off_left = 300;
    repeat (40) send_random_status();
    wait_all_results();
  endtask

  // Bursts of requests with the sender waiting for every result in between.
  task automatic test_sender_pause();
    src_idle_pct  = 0;
    sink_idle_pct = 30;
    repeat (3) begin
      repeat (15) send_random_status();
      wait_all_results();
    end
  endtask

  initial begin : run_tests
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs with the first idle pattern.
    src_idle_pct  = 10;
    sink_idle_pct = 81;
    test_escalation_order();
    test_dwell_hold_and_release();
    test_backwards_and_gap();
    test_field_extremes();

    test_random_traffic(270, 10, 81, 16'hFFFF);
    test_random_traffic(270, 81, 10, 16'd0);
    test_random_traffic(260, 0, 0, 16'd1);
    test_receiver_hold_off();
    test_sender_pause();

    wait_all_results();
    repeat (10) @(posedge clk);

    $display("Checked %0d results from %0d requests over %0d dwell settings in %0d cycles.",
             results_checked, requests_sent, dwell_writes, cycle_count);
    $display("Covered all overlays, dwell hold and release, backwards time, gaps and stalls.");
    if (overlay_expect_q.size() != 0)
      $display("ERROR: %0d results never arrived", overlay_expect_q.size());
    if (error_count == 0 && overlay_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/pods_pkg.sv
hdl/pods_if.sv
hdl/pods_target.sv
hdl/pods_core.sv
hdl/priority_overlay_dwell_selector_top.sv
dv/tb_priority_overlay_dwell_selector_top.sv
